### sv/parc_pkg.sv
// Shared types, constants and helpers for the packet ACL range classifier.
// Depends on nothing; every other file of the block imports it.
package parc_pkg;

   // Size of each of the four rule lists.
   localparam int RULES_PER_LIST = 1024;
   localparam int NUM_LISTS      = 4;
   localparam int LIST_W         = 2;
   localparam int SLOT_W         = (RULES_PER_LIST > 1) ? $clog2(RULES_PER_LIST) : 1;
   localparam int IDX_W          = $clog2(RULES_PER_LIST + 1);
   localparam int ADDR_W         = LIST_W + SLOT_W;
   localparam int MEM_DEPTH      = NUM_LISTS << SLOT_W;
   localparam int CSR_W          = 11;
   localparam int CTR_W          = 48;
   localparam logic [CTR_W-1:0] CTR_MAX = {CTR_W{1'b1}};

   // Command codes of the request word.
   localparam logic [2:0] CMD_CLASSIFY    = 3'd0;
   localparam logic [2:0] CMD_WR_IN_ALLOW = 3'd1;
   localparam logic [2:0] CMD_WR_IN_DENY  = 3'd2;
   localparam logic [2:0] CMD_WR_EG_ALLOW = 3'd3;
   localparam logic [2:0] CMD_WR_EG_DENY  = 3'd4;

   // Register indexes of the configuration port.
   localparam logic [LIST_W-1:0] CSR_IN_ALLOW_COUNT = 2'd0;
   localparam logic [LIST_W-1:0] CSR_IN_DENY_COUNT  = 2'd1;
   localparam logic [LIST_W-1:0] CSR_EG_ALLOW_COUNT = 2'd2;
   localparam logic [LIST_W-1:0] CSR_EG_DENY_COUNT  = 2'd3;

   // Decision codes and verdicts of the response word.
   localparam logic [1:0] DEC_ALLOW_LIST = 2'd0;
   localparam logic [1:0] DEC_DENY_LIST  = 2'd1;
   localparam logic [1:0] DEC_DEFAULT    = 2'd2;
   localparam logic       VERDICT_ALLOW  = 1'b0;
   localparam logic       VERDICT_DENY   = 1'b1;

   typedef struct packed {
      logic [2:0]  command;
      logic        direction;
      logic [31:0] source_address;
      logic [31:0] dest_address;
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic [7:0]  packet_proto;
      logic [9:0]  rule_slot;
      logic [31:0] range_low;
      logic [31:0] range_high;
      logic [15:0] match_port;
      logic [7:0]  match_proto;
   } parc_req_type;

   typedef struct packed {
      logic             verdict;
      logic [1:0]       decided_by;
      logic [CTR_W-1:0] total_seen;
      logic [CTR_W-1:0] allowed_seen;
      logic [CTR_W-1:0] denied_seen;
      logic [CTR_W-1:0] ingress_seen;
      logic [CTR_W-1:0] egress_seen;
   } parc_rsp_type;

   // One stored rule.
   typedef struct packed {
      logic [31:0] range_high;
      logic [31:0] range_low;
      logic [15:0] match_port;
      logic [7:0]  match_proto;
   } parc_rule_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ALLOW,
      ST_DENY,
      ST_COMMIT
   } parc_state_type;

   // Controller to datapath.
   typedef struct packed {
      logic       write_rule;
      logic       load_pkt;
      logic       clear_idx;
      logic       scan_en;
      logic       phase_deny;
      logic       decide;
      logic [1:0] dec_code;
      logic       commit;
   } parc_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic hit;
      logic done;
   } parc_sts_type;

   function automatic logic [CTR_W-1:0] sat_inc(input logic [CTR_W-1:0] v);
      return (v == CTR_MAX) ? v : v + CTR_W'(1);
   endfunction

endpackage

### sv/parc_ctrl.sv
// Sequencing controller of the classifier: request handshake, scan phases,
// commit of the decision and the response-holding flag. Uses parc_pkg.
module parc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [2:0]            req_command,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output parc_pkg::parc_cmd_type cmd,
   input  parc_pkg::parc_sts_type sts
);
   import parc_pkg::*;

   parc_state_type state_ff, state_in;
   logic           out_full_ff, out_full_in;
   logic           slot_free;

   assign slot_free = !out_full_ff || !rsp_stall;
   assign rsp_valid = out_full_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         out_full_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         out_full_ff <= out_full_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall     = 1'b0;
            cmd.clear_idx = 1'b1;
            if (req_valid) begin
               if (req_command == CMD_CLASSIFY) begin
                  cmd.load_pkt = 1'b1;
                  state_in     = ST_ALLOW;
               end else if (req_command >= CMD_WR_IN_ALLOW &&
                            req_command <= CMD_WR_EG_DENY) begin
                  cmd.write_rule = 1'b1;
               end
            end
         end
         ST_ALLOW: begin
            cmd.scan_en = 1'b1;
            if (sts.hit) begin
               cmd.decide   = 1'b1;
               cmd.dec_code = DEC_ALLOW_LIST;
               state_in     = ST_COMMIT;
            end else if (sts.done) begin
               cmd.clear_idx = 1'b1;
               state_in      = ST_DENY;
            end
         end
         ST_DENY: begin
            cmd.scan_en    = 1'b1;
            cmd.phase_deny = 1'b1;
            if (sts.hit) begin
               cmd.decide   = 1'b1;
               cmd.dec_code = DEC_DENY_LIST;
               state_in     = ST_COMMIT;
            end else if (sts.done) begin
               cmd.decide   = 1'b1;
               cmd.dec_code = DEC_DEFAULT;
               state_in     = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (slot_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         out_full_in = 1'b1;
      end else if (out_full_ff && !rsp_stall) begin
         out_full_in = 1'b0;
      end else begin
         out_full_in = out_full_ff;
      end
   end

   // A response only appears after a commit.
   a_full_after_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(out_full_ff) |-> $past(state_ff == ST_COMMIT))
      else $error("response raised without a commit");

   // The commit state is only reached from a scan phase.
   a_commit_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT) |-> ($past(state_ff) == ST_ALLOW ||
         $past(state_ff) == ST_DENY || $past(state_ff) == ST_COMMIT))
      else $error("commit state entered from idle");

   // Rule hits are only reported while a list is being scanned.
   a_hit_in_scan: assert property (@(posedge clock) disable iff (reset)
      sts.hit |-> (state_ff == ST_ALLOW || state_ff == ST_DENY))
      else $error("rule hit outside a scan phase");

endmodule

### sv/parc_dp.sv
// Datapath of the classifier: rule memory, scan index, rule compare,
// list-size registers, saturating counters and the response register. Uses parc_pkg.
module parc_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  parc_pkg::parc_cmd_type cmd,
   output parc_pkg::parc_sts_type sts,
   input  parc_pkg::parc_req_type req_data,
   input  logic                  csr_wr_en,
   input  logic [parc_pkg::LIST_W-1:0] csr_index,
   input  logic [parc_pkg::CSR_W-1:0]  csr_wdata,
   output parc_pkg::parc_rsp_type rsp_data
);
   import parc_pkg::*;

   // Rule storage; contents are undefined until written.
   parc_rule_type rule_mem [MEM_DEPTH];
   parc_rule_type rd_entry_ff;
   parc_rule_type wr_entry;

   logic [CSR_W-1:0]  count_ff [NUM_LISTS];
   logic [CSR_W-1:0]  count_in [NUM_LISTS];

   logic [31:0]       pkt_addr_ff, pkt_addr_in;
   logic [15:0]       pkt_sport_ff, pkt_sport_in;
   logic [15:0]       pkt_dport_ff, pkt_dport_in;
   logic [7:0]        pkt_proto_ff, pkt_proto_in;
   logic              pkt_dir_ff, pkt_dir_in;

   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              rd_valid_ff, rd_valid_in;
   logic [1:0]        dec_ff, dec_in;

   logic [CTR_W-1:0]  total_ff, total_in;
   logic [CTR_W-1:0]  allowed_ff, allowed_in;
   logic [CTR_W-1:0]  denied_ff, denied_in;
   logic [CTR_W-1:0]  ingress_ff, ingress_in;
   logic [CTR_W-1:0]  egress_ff, egress_in;
   parc_rsp_type      rsp_ff, rsp_in;

   logic [LIST_W-1:0] list_sel;
   logic [CSR_W-1:0]  cur_count;
   logic [IDX_W-1:0]  n_lim;
   logic              issue;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic [LIST_W-1:0] wr_list;
   logic [31:0]       slot_wide;
   logic              wr_en;
   logic              addr_ok, port_ok, proto_ok;
   logic              verdict;

   // Configuration registers.
   always_comb begin
      for (int i = 0; i < NUM_LISTS; i++) begin
         count_in[i] = count_ff[i];
      end
      if (csr_wr_en) begin
         count_in[csr_index] = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LISTS; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < NUM_LISTS; i++) begin
            count_ff[i] <= count_in[i];
         end
      end
   end

   // Rule writes.
   assign slot_wide = 32'(req_data.rule_slot);
   assign wr_list   = LIST_W'(req_data.command - CMD_WR_IN_ALLOW);
   assign wr_addr   = {wr_list, slot_wide[SLOT_W-1:0]};
   assign wr_en     = cmd.write_rule && (slot_wide < RULES_PER_LIST);
   assign wr_entry  = '{range_high:  req_data.range_high,
                        range_low:   req_data.range_low,
                        match_port:  req_data.match_port,
                        match_proto: req_data.match_proto};

   // Scan of the current list.
   assign list_sel  = {pkt_dir_ff, cmd.phase_deny};
   assign cur_count = count_ff[list_sel];
   assign n_lim     = (32'(cur_count) > RULES_PER_LIST) ? IDX_W'(RULES_PER_LIST)
                                                         : IDX_W'(cur_count);
   assign issue     = cmd.scan_en && !sts.hit && (idx_ff < n_lim);
   assign rd_addr   = {list_sel, idx_ff[SLOT_W-1:0]};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rule_mem[wr_addr] <= wr_entry;
      end
      if (issue) begin
         rd_entry_ff <= rule_mem[rd_addr];
      end
   end

   // Compare of the entry read in the previous cycle.
   assign addr_ok  = (pkt_addr_ff >= rd_entry_ff.range_low) &&
                     (pkt_addr_ff <= rd_entry_ff.range_high);
   assign port_ok  = (rd_entry_ff.match_port == 16'd0) ||
                     (rd_entry_ff.match_port == pkt_sport_ff) ||
                     (rd_entry_ff.match_port == pkt_dport_ff);
   assign proto_ok = (rd_entry_ff.match_proto == 8'd0) ||
                     (rd_entry_ff.match_proto == pkt_proto_ff);
   assign sts.hit  = rd_valid_ff && addr_ok && port_ok && proto_ok;
   assign sts.done = (idx_ff >= n_lim) && !rd_valid_ff;

   always_comb begin
      pkt_addr_in  = pkt_addr_ff;
      pkt_sport_in = pkt_sport_ff;
      pkt_dport_in = pkt_dport_ff;
      pkt_proto_in = pkt_proto_ff;
      pkt_dir_in   = pkt_dir_ff;
      if (cmd.load_pkt) begin
         pkt_addr_in  = req_data.direction ? req_data.dest_address
                                           : req_data.source_address;
         pkt_sport_in = req_data.source_port;
         pkt_dport_in = req_data.dest_port;
         pkt_proto_in = req_data.packet_proto;
         pkt_dir_in   = req_data.direction;
      end
      if (cmd.clear_idx) begin
         idx_in = '0;
      end else if (issue) begin
         idx_in = idx_ff + IDX_W'(1);
      end else begin
         idx_in = idx_ff;
      end
      rd_valid_in = issue;
      dec_in      = cmd.decide ? cmd.dec_code : dec_ff;
   end

   // Counters and response register, updated on commit.
   assign verdict = (dec_ff == DEC_DENY_LIST) ? VERDICT_DENY : VERDICT_ALLOW;

   always_comb begin
      total_in   = total_ff;
      allowed_in = allowed_ff;
      denied_in  = denied_ff;
      ingress_in = ingress_ff;
      egress_in  = egress_ff;
      rsp_in     = rsp_ff;
      if (cmd.commit) begin
         total_in = sat_inc(total_ff);
         if (pkt_dir_ff) begin
            egress_in = sat_inc(egress_ff);
         end else begin
            ingress_in = sat_inc(ingress_ff);
         end
         if (verdict == VERDICT_DENY) begin
            denied_in = sat_inc(denied_ff);
         end else begin
            allowed_in = sat_inc(allowed_ff);
         end
         rsp_in = '{verdict:      verdict,
                    decided_by:   dec_ff,
                    total_seen:   total_in,
                    allowed_seen: allowed_in,
                    denied_seen:  denied_in,
                    ingress_seen: ingress_in,
                    egress_seen:  egress_in};
      end
   end

   always_ff @(posedge clock) begin
      pkt_addr_ff  <= pkt_addr_in;
      pkt_sport_ff <= pkt_sport_in;
      pkt_dport_ff <= pkt_dport_in;
      pkt_proto_ff <= pkt_proto_in;
      pkt_dir_ff   <= pkt_dir_in;
      idx_ff       <= idx_in;
      dec_ff       <= dec_in;
      rsp_ff       <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
         total_ff    <= '0;
         allowed_ff  <= '0;
         denied_ff   <= '0;
         ingress_ff  <= '0;
         egress_ff   <= '0;
      end else begin
         rd_valid_ff <= rd_valid_in;
         total_ff    <= total_in;
         allowed_ff  <= allowed_in;
         denied_ff   <= denied_in;
         ingress_ff  <= ingress_in;
         egress_ff   <= egress_in;
      end
   end

   assign rsp_data = rsp_ff;

   // Every partial counter moves together with the total, so none passes it.
   a_ctr_order: assert property (@(posedge clock) disable iff (reset)
      (total_ff >= allowed_ff) && (total_ff >= denied_ff) &&
      (total_ff >= ingress_ff) && (total_ff >= egress_ff))
      else $error("partial counter exceeds total");

   // Read data is only marked valid after a read issued during a scan.
   a_read_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> $past(cmd.scan_en))
      else $error("rule read valid outside a scan");

endmodule

### sv/packet_acl_range_classifier.sv
// Top level of the packet ACL range classifier: controller plus datapath.
// Depends on parc_pkg, parc_ctrl and parc_dp.
//
//   Port group | Direction | Carries
//   -----------+-----------+-----------------------------------------------
//   req_*      | in        | one command word: classify or rule write
//   rsp_*      | out       | one verdict word with counters per classify
//   csr_*      | in        | list-size register writes, index 0 to 3
//
// A rule write is taken without leaving the idle state. A classify holds the request side
// while it scans the allow list and then the deny list; a match ends the scan early.
// The rule memory delivers one rule per cycle, so the scan sets the rate.
// Reset is synchronous and clears control state, the list sizes and the
// counters; rule memory is not cleared and must be written before use.
// The block stalls requests while a classify is in progress. A finished
// response sits in an output register, so a new word is taken while the
// previous response waits; a second result waits until that register frees.
module packet_acl_range_classifier (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  parc_pkg::parc_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output parc_pkg::parc_rsp_type rsp_data,
   input  logic                  csr_wr_en,
   input  logic [parc_pkg::LIST_W-1:0] csr_index,
   input  logic [parc_pkg::CSR_W-1:0]  csr_wdata
);
   import parc_pkg::*;

   parc_cmd_type cmd;
   parc_sts_type sts;

   // The controller sequences the allow-list scan, then the deny-list scan,
   // and commits the decision once the response register is free.
   parc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_data.command),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .cmd         (cmd),
      .sts         (sts)
   );

   // The datapath holds the rules, compares one per cycle and keeps the
   // saturating counters that go out with every verdict.
   parc_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_data)
   );

endmodule
